FILE: hw/rtl/gtg_pkg.sv
// Package: widths, register indexes, CORDIC constants and the goal limit.
package gtg_pkg;

  localparam int GUARD_BITS   = 8;
  localparam int ATAN_ENTRIES = 24;
  localparam int DEF_CORDIC_STAGES = 16;

  // Datapath widths: offsets are 17 bits, plus guard and growth bits.
  localparam int XY_W = 17 + GUARD_BITS + 3;
  localparam int Z_W  = 32;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [Z_W-1:0] HALF_PI_Q28 = 32'sd421657428;

  typedef enum logic [2:0] {
    REG_GOAL_X         = 3'd0,
    REG_GOAL_Y         = 3'd1,
    REG_GAIN           = 3'd2,
    REG_SPEED_LIMIT    = 3'd3,
    REG_NEAR_DISTANCE  = 3'd4,
    REG_TURN_THRESHOLD = 3'd5
  } reg_idx_t;

  localparam logic [14:0] GOAL_MAX = 15'd24575;

  function automatic logic signed [Z_W-1:0] atan_q28(input int i);
    logic signed [Z_W-1:0] r;
    r = '0;
    case (i)
      0:  r = 32'sd210828714;
      1:  r = 32'sd124459457;
      2:  r = 32'sd65760959;
      3:  r = 32'sd33381290;
      4:  r = 32'sd16755422;
      5:  r = 32'sd8385879;
      6:  r = 32'sd4193963;
      7:  r = 32'sd2097109;
      8:  r = 32'sd1048571;
      9:  r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      19: r = 32'sd512;
      20: r = 32'sd256;
      21: r = 32'sd128;
      22: r = 32'sd64;
      23: r = 32'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/go_to_goal_p_controller.sv
// Top level: pipelined go-to-goal proportional controller.
// One pose enters per cycle while the output register is empty or being read,
// and its speed command appears on the output after the offset stage, the
// unrolled vectoring CORDIC (one rotation per stage), and the magnitude scaling,
// rounding, gain multiply and decision stages.
// All stages advance together when the output register is empty or being read,
// so a stalled result holds the whole pipe and no item is lost.
module go_to_goal_p_controller #(
  parameter int CORDIC_STAGES = gtg_pkg::DEF_CORDIC_STAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] pose_x, [31:16] pose_y, [46:32] pose_heading, [47] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [14:0] linear_speed, [29:15] angular_speed, [31:30] zero
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import gtg_pkg::*;

  localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // Configuration registers
  logic [14:0] goal_x_r, goal_y_r, speed_limit_r, near_distance_r, turn_threshold_r;
  logic [15:0] gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r         <= 15'd6144;
      goal_y_r         <= 15'd12288;
      gain_r           <= 16'd4096;
      speed_limit_r    <= 15'd6144;
      near_distance_r  <= 15'd205;
      turn_threshold_r <= 15'd819;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GOAL_X:
          if (cfg_data[14:0] != 15'd0 && cfg_data[14:0] <= GOAL_MAX) goal_x_r <= cfg_data[14:0];
        REG_GOAL_Y:
          if (cfg_data[14:0] != 15'd0 && cfg_data[14:0] <= GOAL_MAX) goal_y_r <= cfg_data[14:0];
        REG_GAIN:           gain_r           <= cfg_data;
        REG_SPEED_LIMIT:    speed_limit_r    <= cfg_data[14:0];
        REG_NEAR_DISTANCE:  near_distance_r  <= cfg_data[14:0];
        REG_TURN_THRESHOLD: turn_threshold_r <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Global advance: pipe moves when the output slot is free or being taken
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Stage 0: offsets and quadrant pre-rotation
  logic                  v0_r;
  logic signed [XY_W-1:0] x0_r, y0_r;
  logic signed [Z_W-1:0]  z0_r;
  logic signed [14:0]     hd0_r;
  logic                   zero0_r;

  logic signed [16:0] dx, dy;
  logic signed [XY_W-1:0] xe, ye;
  assign dx = $signed({2'b00, goal_x_r}) - $signed({in_tdata[15], in_tdata[15:0]});
  assign dy = $signed({2'b00, goal_y_r}) - $signed({in_tdata[31], in_tdata[31:16]});
  assign xe = XY_W'(dx) <<< GUARD_BITS;
  assign ye = XY_W'(dy) <<< GUARD_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hd0_r   <= $signed(in_tdata[46:32]);
      zero0_r <= (dx == 17'sd0) && (dy == 17'sd0);
      if (xe < 0) begin
        if (ye >= 0) begin
          x0_r <= ye; y0_r <= -xe; z0_r <= HALF_PI_Q28;
        end else begin
          x0_r <= -ye; y0_r <= xe; z0_r <= -HALF_PI_Q28;
        end
      end else begin
        x0_r <= xe; y0_r <= ye; z0_r <= '0;
      end
    end
  end

  // CORDIC rotation stages: stage i reads si_*[i] and registers c*_r[i]
  logic                   cv_r  [NS];
  logic signed [XY_W-1:0] cx_r  [NS];
  logic signed [XY_W-1:0] cy_r  [NS];
  logic signed [Z_W-1:0]  cz_r  [NS];
  logic signed [14:0]     chd_r [NS];
  logic                   czr_r [NS];

  logic                   si_v  [NS];
  logic signed [XY_W-1:0] si_x  [NS];
  logic signed [XY_W-1:0] si_y  [NS];
  logic signed [Z_W-1:0]  si_z  [NS];
  logic signed [14:0]     si_hd [NS];
  logic                   si_zr [NS];

  // Route stage 0 into the first rotation and each stage into the next
  always_comb begin
    si_v[0] = v0_r; si_x[0] = x0_r; si_y[0] = y0_r;
    si_z[0] = z0_r; si_hd[0] = hd0_r; si_zr[0] = zero0_r;
    for (int i = 1; i < NS; i++) begin
      si_v[i]  = cv_r[i-1];
      si_x[i]  = cx_r[i-1];
      si_y[i]  = cy_r[i-1];
      si_z[i]  = cz_r[i-1];
      si_hd[i] = chd_r[i-1];
      si_zr[i] = czr_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) cv_r[i] <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i < NS; i++) cv_r[i] <= si_v[i];
    end
  end

  // Rotate toward the x axis, one fixed shift per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NS; i++) begin
        chd_r[i] <= si_hd[i];
        czr_r[i] <= si_zr[i];
        if (si_y[i] > 0) begin
          cx_r[i] <= si_x[i] + (si_y[i] >>> i);
          cy_r[i] <= si_y[i] - (si_x[i] >>> i);
          cz_r[i] <= si_z[i] + atan_q28(i);
        end else begin
          cx_r[i] <= si_x[i] - (si_y[i] >>> i);
          cy_r[i] <= si_y[i] + (si_x[i] >>> i);
          cz_r[i] <= si_z[i] - atan_q28(i);
        end
      end
    end
  end

  // Stage A: gain correction multiply and bearing rounding
  logic                  va_r;
  logic [XY_W+29:0]      prod_a_r;
  logic signed [15:0]    bear_a_r;
  logic signed [14:0]    hda_r;
  logic [XY_W-1:0]       ux;
  logic signed [Z_W:0]   zr;
  assign ux = (cx_r[NS-1] > 0) ? cx_r[NS-1] : '0;
  assign zr = (Z_W+1)'(cz_r[NS-1]) + (Z_W+1)'(32768);

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= cv_r[NS-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_a_r <= (XY_W+30)'(ux) * (XY_W+30)'(INV_GAIN_Q30);
      bear_a_r <= czr_r[NS-1] ? 16'sd0 : 16'(zr >>> 16);
      hda_r    <= chd_r[NS-1];
    end
  end

  // Stage B: distance rounding and absolute heading error
  logic        vb_r;
  logic [16:0] dist_b_r;
  logic [15:0] err_b_r;
  logic [XY_W+29:0] prnd;
  logic signed [16:0] errs;
  assign prnd = prod_a_r + ((XY_W+30)'(1) << (29 + GUARD_BITS));
  assign errs = 17'(bear_a_r) - 17'(hda_r);

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dist_b_r <= 17'(prnd >> (30 + GUARD_BITS));
      err_b_r  <= (errs < 0) ? 16'(-errs) : 16'(errs);
    end
  end

  // Stage C: gain multiply and threshold compares
  logic        vc_r;
  logic [32:0] lin_c_r;
  logic [15:0] err_c_r;
  logic        near_c_r, turn_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (adv) vc_r <= vb_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      lin_c_r  <= gain_r * dist_b_r;
      err_c_r  <= err_b_r;
      near_c_r <= !(dist_b_r > {2'b00, near_distance_r});
      turn_c_r <= err_b_r > {1'b0, turn_threshold_r};
    end
  end

  // Stage D: round, saturate, select the command
  logic [33:0] lin_r34;
  logic [21:0] lin_sh;
  logic [14:0] lin_sat;
  assign lin_r34 = {1'b0, lin_c_r} + 34'd2048;
  assign lin_sh  = lin_r34[33:12];
  assign lin_sat = (lin_sh > {7'd0, speed_limit_r}) ? speed_limit_r : lin_sh[14:0];

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (adv) out_tvalid <= vc_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata[31:30] <= 2'b00;
      if (near_c_r) begin
        out_tdata[29:0] <= '0;
      end else if (turn_c_r) begin
        out_tdata[14:0]  <= '0;
        out_tdata[29:15] <= err_c_r[14:0];
      end else begin
        out_tdata[14:0]  <= lin_sat;
        out_tdata[29:15] <= '0;
      end
    end
  end

endmodule
